// ----- rtl/hrbe_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrbe_pkg
// Shared types, character codes and the hex digit decoder of the hex record
// byte extractor.
// ----------------------------------------------------------------------------
package hrbe_pkg;

    localparam int CHAR_W  = 8;
    localparam int ADDR_W  = 16;
    localparam int BYTE_W  = 8;
    localparam int NIBBLE_W = 4;

    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_COLON   = 8'h3A;

    // Parser phase, one-hot.
    typedef enum logic [6:0] {
        PH_LINE_START = 7'b0000001,
        PH_COUNT      = 7'b0000010,
        PH_ADDR_HI    = 7'b0000100,
        PH_ADDR_LO    = 7'b0001000,
        PH_TYPE       = 7'b0010000,
        PH_DATA       = 7'b0100000,
        PH_IGNORE     = 7'b1000000
    } hrbe_phase_t;

    // One extracted data byte on its way to the output register.
    typedef struct packed {
        logic [ADDR_W-1:0] byte_address;
        logic [BYTE_W-1:0] data_byte;
        logic              last_of_record;
    } hrbe_result_t;

    // Hex digit value; anything that is not a hex digit counts as zero.
    function automatic logic [NIBBLE_W-1:0] digit_value(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] d;
        begin
            d = '0;
            if (c >= 8'h30 && c <= 8'h39) begin
                d = c - 8'h30;
            end else if (c >= 8'h41 && c <= 8'h46) begin
                d = c - 8'h37;
            end else if (c >= 8'h61 && c <= 8'h66) begin
                d = c - 8'h57;
            end
            return d[NIBBLE_W-1:0];
        end
    endfunction

endpackage

// ----- rtl/hrbe_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrbe_parser
// Record state machine: takes one character per step and yields at most one
// data byte with its address and last-of-record flag.
// ----------------------------------------------------------------------------
module hrbe_parser (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step_en,
    input  logic [hrbe_pkg::CHAR_W-1:0]   char_in,
    output logic                          emit,
    output hrbe_pkg::hrbe_result_t        result
);
    import hrbe_pkg::*;

    hrbe_phase_t          phase_reg,   phase_next;
    logic                 dpos_reg,    dpos_next;
    logic [NIBBLE_W-1:0]  high_reg,    high_next;
    logic [BYTE_W-1:0]    count_reg,   count_next;
    logic [BYTE_W-1:0]    done_reg,    done_next;
    logic [ADDR_W-1:0]    addr_reg,    addr_next;

    logic [NIBBLE_W-1:0]  digit;
    logic [BYTE_W-1:0]    pair_byte;
    logic [BYTE_W-1:0]    done_inc;
    logic                 is_last;

    assign digit     = digit_value(char_in);
    assign pair_byte = {high_reg, digit};
    assign done_inc  = done_reg + BYTE_W'(1);
    assign is_last   = (done_inc == count_reg);

    always_comb begin
        phase_next = phase_reg;
        dpos_next  = dpos_reg;
        high_next  = high_reg;
        count_next = count_reg;
        done_next  = done_reg;
        addr_next  = addr_reg;
        emit       = 1'b0;
        result.byte_address   = addr_reg + {{(ADDR_W-BYTE_W){1'b0}}, done_reg};
        result.data_byte      = pair_byte;
        result.last_of_record = is_last;

        if (step_en) begin
            if (char_in == CHAR_NEWLINE) begin
                phase_next = PH_LINE_START;
                dpos_next  = 1'b0;
            end else begin
                unique case (phase_reg)
                    PH_LINE_START: begin
                        phase_next = (char_in == CHAR_COLON) ? PH_COUNT : PH_IGNORE;
                        dpos_next  = 1'b0;
                    end
                    PH_COUNT, PH_ADDR_HI, PH_ADDR_LO, PH_TYPE, PH_DATA: begin
                        if (!dpos_reg) begin
                            high_next = digit;
                            dpos_next = 1'b1;
                        end else begin
                            dpos_next = 1'b0;
                            unique case (phase_reg)
                                PH_COUNT: begin
                                    count_next = pair_byte;
                                    phase_next = PH_ADDR_HI;
                                end
                                PH_ADDR_HI: begin
                                    addr_next  = {pair_byte, {BYTE_W{1'b0}}};
                                    phase_next = PH_ADDR_LO;
                                end
                                PH_ADDR_LO: begin
                                    addr_next  = {addr_reg[ADDR_W-1:BYTE_W], pair_byte};
                                    phase_next = PH_TYPE;
                                end
                                PH_TYPE: begin
                                    done_next  = '0;
                                    phase_next = (count_reg == '0) ? PH_IGNORE : PH_DATA;
                                end
                                default: begin
                                    emit      = 1'b1;
                                    done_next = done_inc;
                                    if (is_last) begin
                                        phase_next = PH_IGNORE;
                                    end
                                end
                            endcase
                        end
                    end
                    default: begin
                        // Rest of an ignored line: nothing changes.
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_LINE_START;
            dpos_reg  <= 1'b0;
            high_reg  <= '0;
            count_reg <= '0;
            done_reg  <= '0;
            addr_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            dpos_reg  <= dpos_next;
            high_reg  <= high_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            addr_reg  <= addr_next;
        end
    end

endmodule

// ----- rtl/hrbe_out_reg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrbe_out_reg
// Result register with valid/ready handshake towards the consumer.
// ----------------------------------------------------------------------------
module hrbe_out_reg (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    load_en,
    input  logic                    load_valid,
    input  hrbe_pkg::hrbe_result_t  load_data,
    output logic                    can_load,
    output logic                    m_valid,
    input  logic                    m_ready,
    output hrbe_pkg::hrbe_result_t  m_data
);
    import hrbe_pkg::*;

    logic         valid_reg, valid_next;
    hrbe_result_t data_reg,  data_next;

    // The register may be refilled when empty or when its beat leaves now.
    assign can_load = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (m_ready) begin
            valid_next = 1'b0;
        end
        if (load_en && load_valid) begin
            valid_next = 1'b1;
            data_next  = load_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

// ----- rtl/hex_record_byte_extractor_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_record_byte_extractor_unit
// Extracts addressed data bytes from a hex-record character stream.
// ----------------------------------------------------------------------------
// The block takes one ASCII character per input beat and accepts a new beat
// in every clock cycle, as long as the result register is empty or its beat
// is being taken in the same cycle. A record is recognised only when a colon
// is the first character of a line; the following digit pair gives the
// byte count, the next two a big-endian start address, the type pair is
// skipped and each further pair yields one data byte. A data byte appears on
// the result channel in the cycle after the beat carrying its low digit, with
// its address (start address plus byte index, wrapping at 16 bits) and a
// flag on the final byte the count announced. Characters that are not hex
// digits count as zero, the checksum is ignored, and a newline ends a record
// at once, dropping any bytes that have not yet arrived. The record state
// machine updates in a single step between the input beat and the result
// register, and s_ready falls only while a result beat is held by a stalled
// consumer.
// ----------------------------------------------------------------------------
module hex_record_byte_extractor_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [hrbe_pkg::CHAR_W-1:0]   s_char_in,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [hrbe_pkg::ADDR_W-1:0]   m_byte_address,
    output logic [hrbe_pkg::BYTE_W-1:0]   m_data_byte,
    output logic                          m_last_of_record
);
    import hrbe_pkg::*;

    logic         step_en;
    logic         emit;
    logic         can_load;
    hrbe_result_t result;
    hrbe_result_t m_data;

    // A character is consumed whenever the result register can take
    // whatever it may produce.
    assign s_ready = can_load;
    assign step_en = s_valid && can_load;

    hrbe_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .char_in (s_char_in),
        .emit    (emit),
        .result  (result)
    );

    hrbe_out_reg u_out_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load_en    (step_en),
        .load_valid (emit),
        .load_data  (result),
        .can_load   (can_load),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    assign m_byte_address   = m_data.byte_address;
    assign m_data_byte      = m_data.data_byte;
    assign m_last_of_record = m_data.last_of_record;

endmodule

// ----- rtl/hrbe_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrbe_checker
// Port-level checks of the hex record byte extractor, bound to the top level.
// ----------------------------------------------------------------------------
module hrbe_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic [hrbe_pkg::CHAR_W-1:0]   s_char_in,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [hrbe_pkg::ADDR_W-1:0]   m_byte_address,
    input logic [hrbe_pkg::BYTE_W-1:0]   m_data_byte,
    input logic                          m_last_of_record
);
    import hrbe_pkg::*;

    // A stalled result beat stays put with its payload unchanged.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_byte_address)
            && $stable(m_data_byte) && $stable(m_last_of_record))
        else $error("stalled result beat changed");

    // Reset leaves the result channel empty.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // With nothing held, the block must take input.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty result register");

    // A newline never produces a data byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_char_in == CHAR_NEWLINE) && (!m_valid || m_ready)
            |=> !m_valid)
        else $error("newline produced a data byte");

endmodule

bind hex_record_byte_extractor_unit hrbe_checker u_hrbe_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .s_char_in        (s_char_in),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_byte_address   (m_byte_address),
    .m_data_byte      (m_data_byte),
    .m_last_of_record (m_last_of_record)
);
